FILE: src/clws_pkg.sv
// clws_pkg: shared types, codes and helpers for the character lcd write sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package clws_pkg;

    // operation codes of an input request
    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_CHAR    = 2'd1,
        OP_CURSOR  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic CFG_FOUR_BIT_BUS      = 1'b0;
    localparam logic CFG_NIBBLE_ON_LOW_PINS = 1'b1;

    // display rows and their ddram offsets
    localparam logic [2:0] ROW_2 = 3'd2;
    localparam logic [2:0] ROW_3 = 3'd3;
    localparam logic [2:0] ROW_4 = 3'd4;
    localparam logic [7:0] ROW_OFFSET_1   = 8'h00;
    localparam logic [7:0] ROW_OFFSET_2   = 8'h40;
    localparam logic [7:0] ROW_OFFSET_3   = 8'h10;
    localparam logic [7:0] ROW_OFFSET_4   = 8'h50;
    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;

    // snapshot steps of one write
    localparam int          STEP_W       = 3;
    localparam logic [2:0]  STEP_HI_DATA = 3'd2;
    localparam logic [2:0]  STEP_LAST_8  = 3'd3;
    localparam logic [2:0]  STEP_LO_DATA = 3'd5;
    localparam logic [2:0]  STEP_LAST_4  = 3'd6;

    // depth of the queue between front and back
    localparam int CMD_QUEUE_DEPTH = 2;

    // input request as seen on the push side
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic [2:0] row;
        logic [3:0] column;
    } t_in_item;

    // one pin snapshot on the pop side
    typedef struct packed {
        logic       register_select;
        logic       read_not_write;
        logic       enable_pin;
        logic [7:0] data_pins;
        logic       last_step;
    } t_out_item;

    // decoded write waiting for the back end
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } t_cmd;

    // bus mode settings handed to the back end
    typedef struct packed {
        logic four_bit_bus;
        logic nibble_on_low_pins;
    } t_mode;

endpackage

`default_nettype wire

FILE: src/char_lcd_write_sequencer_unit.sv
// char_lcd_write_sequencer_unit: top level of the character lcd write sequencer
// depends on clws_pkg, clws_front, clws_queue, clws_back
`default_nettype none

// Each request (command byte, character byte or cursor move) becomes a run of
// pin snapshots (RS, RW, E, data bus) on the pop side: seven snapshots in
// 4-bit bus mode, four in 8-bit mode, the last one flagged by last_step.
// Operation code 3 is accepted and produces nothing. The back-end step counter
// emits one snapshot per cycle while pop keeps up; consecutive requests follow
// with no gap. A short command queue lets requests be pushed while an earlier
// one is still being sequenced. Rows outside 1..4 on a cursor move act as
// row 1. The two mode registers are written through the cfg port, which is
// always ready; write them only while no request is in flight.
module char_lcd_write_sequencer_unit #(
    parameter int QUEUE_DEPTH = clws_pkg::CMD_QUEUE_DEPTH
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  wire clws_pkg::t_in_item   i_item,
    output logic                      empty,
    input  wire                       pop,
    output clws_pkg::t_out_item       o_result,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire                       i_cfg_index,
    input  wire                       i_cfg_data
);
    import clws_pkg::*;

    t_mode r_mode;
    t_cmd  front_cmd, queue_cmd;
    logic  front_push, queue_full, queue_valid, queue_pop;

    // mode registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode.four_bit_bus       <= 1'b1;
            r_mode.nibble_on_low_pins <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOUR_BIT_BUS:       r_mode.four_bit_bus       <= i_cfg_data;
                CFG_NIBBLE_ON_LOW_PINS: r_mode.nibble_on_low_pins <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request decode
    clws_front u_front (
        .i_item       (i_item),
        .i_push       (push),
        .i_queue_full (queue_full),
        .o_full       (full),
        .o_cmd_push   (front_push),
        .o_cmd        (front_cmd)
    );

    // decoupling queue
    clws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // snapshot sequencer
    clws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

FILE: src/clws_front.sv
// clws_front: accepts requests, drops unused codes, turns cursor moves into commands
// depends on clws_pkg
`default_nettype none

module clws_front (
    input  wire clws_pkg::t_in_item i_item,
    input  wire                     i_push,
    input  wire                     i_queue_full,
    output logic                    o_full,
    output logic                    o_cmd_push,
    output clws_pkg::t_cmd          o_cmd
);
    import clws_pkg::*;

    logic [7:0] row_offset;
    t_op        op;

    assign op = t_op'(i_item.operation);

    // row offset lookup, unknown rows fall back to row 1
    always_comb begin
        unique case (i_item.row)
            ROW_2:   row_offset = ROW_OFFSET_2;
            ROW_3:   row_offset = ROW_OFFSET_3;
            ROW_4:   row_offset = ROW_OFFSET_4;
            default: row_offset = ROW_OFFSET_1;
        endcase
    end

    // classify the request
    always_comb begin
        unique case (op)
            OP_COMMAND: begin
                o_cmd.rs   = 1'b0;
                o_cmd.data = i_item.byte_value;
            end
            OP_CHAR: begin
                o_cmd.rs   = 1'b1;
                o_cmd.data = i_item.byte_value;
            end
            OP_CURSOR: begin
                o_cmd.rs   = 1'b0;
                o_cmd.data = ({4'd0, i_item.column} + row_offset) | SET_DDRAM_ADDR;
            end
            default: begin
                o_cmd.rs   = 1'b0;
                o_cmd.data = i_item.byte_value;
            end
        endcase
    end

    // unused code is taken and dropped
    assign o_full     = i_queue_full;
    assign o_cmd_push = i_push && !i_queue_full && (op != OP_NONE);

endmodule

`default_nettype wire

FILE: src/clws_queue.sv
// clws_queue: small fifo of decoded writes between front and back
// depends on clws_pkg
`default_nettype none

module clws_queue #(
    parameter int DEPTH = clws_pkg::CMD_QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wire clws_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_valid,
    output clws_pkg::t_cmd  o_cmd
);
    import clws_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/clws_back.sv
// clws_back: steps through the pin snapshots of each write, one per cycle
// while the output register is free or being taken; depends on clws_pkg
`default_nettype none

module clws_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire clws_pkg::t_mode  i_mode,
    input  wire                   i_cmd_valid,
    input  wire clws_pkg::t_cmd   i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_empty,
    input  wire                   i_pop,
    output clws_pkg::t_out_item   o_result
);
    import clws_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [7:0]        r_latch;
    logic              r_out_valid;
    t_out_item         r_out;

    logic       advance, emit, last, enable;
    logic [7:0] n_latch;

    // put a nibble on its half of the bus, keep the other half
    function automatic logic [7:0] place_nibble(input logic [7:0] latch,
                                                input logic [3:0] nib,
                                                input logic       low_pins);
        place_nibble = low_pins ? {latch[7:4], nib} : {nib, latch[3:0]};
    endfunction

    // snapshot for the current step
    always_comb begin
        n_latch = r_latch;
        if (r_step == STEP_HI_DATA) begin
            n_latch = i_mode.four_bit_bus
                    ? place_nibble(r_latch, i_cmd.data[7:4], i_mode.nibble_on_low_pins)
                    : i_cmd.data;
        end else if (r_step == STEP_LO_DATA && i_mode.four_bit_bus) begin
            n_latch = place_nibble(r_latch, i_cmd.data[3:0], i_mode.nibble_on_low_pins);
        end
        last   = i_mode.four_bit_bus ? (r_step == STEP_LAST_4) : (r_step == STEP_LAST_8);
        enable = (r_step == 3'd1) || (r_step == STEP_HI_DATA)
              || (r_step == 3'd4) || (r_step == STEP_LO_DATA);
    end

    // output register frees up when empty or being taken
    assign advance   = !r_out_valid || i_pop;
    assign emit      = i_cmd_valid && advance;
    assign o_cmd_pop = emit && last;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // step counter, bus latch and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_step      <= last ? '0 : r_step + 1'b1;
                r_latch     <= n_latch;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.register_select <= i_cmd.rs;
            r_out.read_not_write  <= 1'b0;
            r_out.enable_pin      <= enable;
            r_out.data_pins       <= n_latch;
            r_out.last_step       <= last;
        end
    end

endmodule

`default_nettype wire

FILE: src/clws_checker.sv
// clws_checker: port-level checks for the character lcd write sequencer
// depends on clws_pkg; bound to char_lcd_write_sequencer_unit
`default_nettype none

module clws_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      full,
    input wire                      empty,
    input wire                      pop,
    input wire clws_pkg::t_out_item o_result
);
    import clws_pkg::*;

    // nothing is pending when reset is released
    a_reset_clean: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("results or full seen right after reset");

    // writes only, rw never driven high
    a_rw_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !o_result.read_not_write)
        else $error("read_not_write high on a result");

    // the final snapshot always drops the strobe
    a_last_strobe_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.last_step) |-> !o_result.enable_pin)
        else $error("last snapshot with enable high");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind char_lcd_write_sequencer_unit clws_checker u_clws_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire
